>>> hdl/sdfa_pkg.sv
// ----------------------------------------------------------------------------
// sdfa_pkg: shared types and constants
// Widths, queue depths and the item types passed between the front end,
// the term queue and the accumulating back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sdfa_pkg;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int DIFF_W   = 18;   // x - 2*x2 + x0 spans +-131070
  localparam int PROD_W   = DIFF_W + SAMPLE_W;
  localparam int SQ_W     = 2 * SAMPLE_W;
  localparam int ACC_W    = 64;

  // Warm-up: samples needed before a term is formed
  localparam int CNT_W = 3;
  localparam logic [CNT_W-1:0] WARMUP = CNT_W'(4);

  // Term queue between front and back
  localparam int TQ_DEPTH = 4;
  localparam int TQ_PTR_W = 2;
  localparam int TQ_CNT_W = 3;

  // Result queue at the output
  localparam int RQ_DEPTH = 2;
  localparam int RQ_PTR_W = 1;
  localparam int RQ_CNT_W = 2;

  // One classified item handed from front to back
  typedef struct packed {
    logic signed [DIFF_W-1:0]   diff;
    logic signed [SAMPLE_W-1:0] centre;
    logic                       term;   // window full: add to the sums
    logic                       last;   // end of run: emit and clear
  } term_t;

  // One result item
  typedef struct packed {
    logic [ACC_W-1:0] numerator;
    logic [ACC_W-1:0] denominator;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/sdfa_front.sv
// ----------------------------------------------------------------------------
// sdfa_front: sample window and item classification
// Keeps the four previous samples and the warm-up count, forms the second
// difference and centre sample of each accepted item, and marks whether
// the item contributes a term and whether it closes the run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdfa_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                accept_i,
  input  wire logic signed [sdfa_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                end_of_run_i,
  output      sdfa_pkg::term_t                     term_o
);

  // [0] oldest .. [3] newest
  logic signed [sdfa_pkg::SAMPLE_W-1:0] win_q [4];
  logic signed [sdfa_pkg::SAMPLE_W-1:0] win_d [4];
  logic [sdfa_pkg::CNT_W-1:0]           cnt_q, cnt_d;

  logic [sdfa_pkg::DIFF_W-1:0] x_ext, x0_ext, x2_ext;

  // Second difference around the centre sample
  assign x_ext  = {{(sdfa_pkg::DIFF_W-sdfa_pkg::SAMPLE_W){sample_i[sdfa_pkg::SAMPLE_W-1]}},
                   sample_i};
  assign x0_ext = {{(sdfa_pkg::DIFF_W-sdfa_pkg::SAMPLE_W){win_q[0][sdfa_pkg::SAMPLE_W-1]}},
                   win_q[0]};
  assign x2_ext = {{(sdfa_pkg::DIFF_W-sdfa_pkg::SAMPLE_W){win_q[2][sdfa_pkg::SAMPLE_W-1]}},
                   win_q[2]};

  always_comb begin
    term_o.diff   = x_ext - {x2_ext[sdfa_pkg::DIFF_W-2:0], 1'b0} + x0_ext;
    term_o.centre = win_q[2];
    term_o.term   = (cnt_q == sdfa_pkg::WARMUP);
    term_o.last   = end_of_run_i;
  end

  // Window shift and warm-up count; a run end returns both to reset
  always_comb begin
    win_d = win_q;
    cnt_d = cnt_q;
    if (accept_i) begin
      if (end_of_run_i) begin
        for (int i = 0; i < 4; i++) begin
          win_d[i] = '0;
        end
        cnt_d = '0;
      end else begin
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = win_q[3];
        win_d[3] = sample_i;
        if (cnt_q != sdfa_pkg::WARMUP) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        win_q[i] <= '0;
      end
      cnt_q <= '0;
    end else begin
      win_q <= win_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sdfa_term_queue.sv
// ----------------------------------------------------------------------------
// sdfa_term_queue: short queue between front and back
// Holds classified items so the front keeps accepting while the back
// waits on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdfa_term_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_i,
  input  wire sdfa_pkg::term_t wr_data_i,
  output      logic            full_o,
  input  wire logic            rd_i,
  output      logic            empty_o,
  output      sdfa_pkg::term_t rd_data_o
);

  sdfa_pkg::term_t                mem_q [sdfa_pkg::TQ_DEPTH];
  logic [sdfa_pkg::TQ_PTR_W-1:0]  wptr_q, rptr_q;
  logic [sdfa_pkg::TQ_CNT_W-1:0]  cnt_q;
  logic                           do_wr, do_rd;

  assign full_o    = (cnt_q == sdfa_pkg::TQ_CNT_W'(sdfa_pkg::TQ_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i & ~full_o;
  assign do_rd     = rd_i & ~empty_o;
  assign rd_data_o = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/sdfa_back.sv
// ----------------------------------------------------------------------------
// sdfa_back: multiply, accumulate and result queue
// Stage 1 registers d*c and c*c; stage 2 folds them into the sums and,
// on a run end, writes one result and clears the sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sdfa_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            tq_empty_i,
  input  wire sdfa_pkg::term_t tq_data_i,
  output      logic            tq_rd_o,
  input  wire logic            pop_i,
  output      logic            empty_o,
  output      sdfa_pkg::result_t result_o
);

  // Multiply stage
  logic                               s1_valid_q;
  logic                               s1_term_q, s1_last_q;
  logic signed [sdfa_pkg::PROD_W-1:0] s1_prod_q, prod;
  logic signed [sdfa_pkg::SQ_W-1:0]   s1_sq_q, sq;
  logic                               s1_adv, s1_load;

  // Sums; the numerator is kept negated
  logic [sdfa_pkg::ACC_W-1:0] nsum_q, nsum_d, dsum_q, dsum_d;
  logic [sdfa_pkg::ACC_W-1:0] nterm, dterm;

  // Result queue
  sdfa_pkg::result_t             rq_q [sdfa_pkg::RQ_DEPTH];
  logic [sdfa_pkg::RQ_PTR_W-1:0] rq_wptr_q, rq_rptr_q;
  logic [sdfa_pkg::RQ_CNT_W-1:0] rq_cnt_q;
  logic                          rq_full, rq_wr, rq_rd;

  assign rq_full = (rq_cnt_q == sdfa_pkg::RQ_CNT_W'(sdfa_pkg::RQ_DEPTH));
  assign empty_o = (rq_cnt_q == '0);
  assign rq_rd   = pop_i & ~empty_o;

  // Stage 1 moves on unless it holds a run end with no result slot
  assign s1_adv  = s1_valid_q & (~s1_last_q | ~rq_full);
  assign s1_load = ~s1_valid_q | s1_adv;
  assign tq_rd_o = s1_load & ~tq_empty_i;
  assign rq_wr   = s1_adv & s1_last_q;

  assign prod = tq_data_i.diff * tq_data_i.centre;
  assign sq   = tq_data_i.centre * tq_data_i.centre;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= ~tq_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tq_rd_o) begin
      s1_prod_q <= prod;
      s1_sq_q   <= sq;
      s1_term_q <= tq_data_i.term;
      s1_last_q <= tq_data_i.last;
    end
  end

  // Accumulate
  always_comb begin
    nterm  = s1_term_q ? {{(sdfa_pkg::ACC_W-sdfa_pkg::PROD_W){s1_prod_q[sdfa_pkg::PROD_W-1]}},
                          s1_prod_q} : '0;
    dterm  = s1_term_q ? {{(sdfa_pkg::ACC_W-sdfa_pkg::SQ_W){1'b0}}, s1_sq_q} : '0;
    nsum_d = nsum_q - nterm;
    dsum_d = dsum_q + dterm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nsum_q <= '0;
      dsum_q <= '0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        nsum_q <= '0;
        dsum_q <= '0;
      end else begin
        nsum_q <= nsum_d;
        dsum_q <= dsum_d;
      end
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (rq_wr) begin
      rq_q[rq_wptr_q].numerator   <= nsum_d;
      rq_q[rq_wptr_q].denominator <= dsum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wptr_q <= '0;
      rq_rptr_q <= '0;
      rq_cnt_q  <= '0;
    end else begin
      if (rq_wr) begin
        rq_wptr_q <= rq_wptr_q + 1'b1;
      end
      if (rq_rd) begin
        rq_rptr_q <= rq_rptr_q + 1'b1;
      end
      if (rq_wr && !rq_rd) begin
        rq_cnt_q <= rq_cnt_q + 1'b1;
      end else if (rq_rd && !rq_wr) begin
        rq_cnt_q <= rq_cnt_q - 1'b1;
      end
    end
  end

  assign result_o = rq_q[rq_rptr_q];

endmodule

`default_nettype wire

>>> hdl/second_difference_frequency_accumulator_unit.sv
// ----------------------------------------------------------------------------
// second_difference_frequency_accumulator_unit: frequency estimator sums
// Accumulates sum(d*c) and sum(c*c) over a run of samples, with
// d = x[n] - 2x[n-2] + x[n-4] and c = x[n-2], and reports them per run.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: drive sample_i / end_of_run_i and
//   raise push; the item is taken on a clock edge where full is low.
//   Output side is a queue read port: while empty is low, numerator_o
//   (negated d*c sum) and denominator_o (c*c sum) show the oldest result;
//   raise pop to take it. One result is produced per item with
//   end_of_run_i set; other items produce none.
//   Throughput is one item per cycle while full is low. A run end passes
//   the term queue, multiply register and result queue before empty falls.
//   The first four samples of a run only fill the window; a run shorter
//   than five samples reports zeros. State returns to zero after each run.
//   If pop is held low, up to two results wait in the result queue; the
//   multiply stage then holds the next run end and the four-entry term
//   queue fills behind it before full is raised. Ordinary samples keep
//   flowing past a stalled receiver until a run end reaches that stage.
//   Reset (rst_ni low) empties both queues and clears window and sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module second_difference_frequency_accumulator_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push,
  output      logic                                full,
  input  wire logic signed [sdfa_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                end_of_run_i,
  output      logic                                empty,
  input  wire logic                                pop,
  output      logic signed [sdfa_pkg::ACC_W-1:0]    numerator_o,
  output      logic signed [sdfa_pkg::ACC_W-1:0]    denominator_o
);

  logic              accept;
  logic              tq_empty, tq_rd;
  sdfa_pkg::term_t   fe_term, tq_data;
  sdfa_pkg::result_t result;

  assign accept = push & ~full;

  // Front end: window and classification
  sdfa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .sample_i     (sample_i),
    .end_of_run_i (end_of_run_i),
    .term_o       (fe_term)
  );

  // Decoupling queue
  sdfa_term_queue u_term_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (fe_term),
    .full_o    (full),
    .rd_i      (tq_rd),
    .empty_o   (tq_empty),
    .rd_data_o (tq_data)
  );

  // Back end: multiply, accumulate, result queue
  sdfa_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tq_empty_i (tq_empty),
    .tq_data_i  (tq_data),
    .tq_rd_o    (tq_rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .result_o   (result)
  );

  assign numerator_o   = result.numerator;
  assign denominator_o = result.denominator;

endmodule

`default_nettype wire

>>> sim/frequency_sum_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_sum_checker: result checker for the frequency accumulator
// Watches the push and pop sides of the block and keeps its own window of
// four samples and both 64-bit sums. On every accepted run end it queues the
// expected result, and it compares each popped result field by field with
// the oldest one.
// ----------------------------------------------------------------------------

module frequency_sum_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  input  logic                                 full,
  input  logic signed [sdfa_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 end_of_run_i,
  input  logic                                 empty,
  input  logic                                 pop,
  input  logic signed [sdfa_pkg::ACC_W-1:0]    numerator_o,
  input  logic signed [sdfa_pkg::ACC_W-1:0]    denominator_o,
  output int                                   error_count_o,
  output int                                   pending_o
);

  // Predicted block state: [0] oldest .. [3] newest
  logic signed [sdfa_pkg::SAMPLE_W-1:0] window_q [4];
  logic [sdfa_pkg::CNT_W-1:0]           seen_q;
  logic [sdfa_pkg::ACC_W-1:0]           dc_sum_q;
  logic [sdfa_pkg::ACC_W-1:0]           cc_sum_q;
  sdfa_pkg::result_t                    run_results_q [$];
  int                                   errors = 0;

  task automatic log_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic clear_run();
    foreach (window_q[i]) window_q[i] = '0;
    seen_q   = '0;
    dc_sum_q = '0;
    cc_sum_q = '0;
  endtask

  // Fold one sample into the sums; a run end queues the expected result
  task automatic take_sample(input logic signed [sdfa_pkg::SAMPLE_W-1:0] x,
                             input logic last);
    longint            diff;
    longint            centre;
    sdfa_pkg::result_t res;
    diff   = longint'(x) - 2 * longint'(window_q[2]) + longint'(window_q[0]);
    centre = longint'(window_q[2]);
    window_q[0] = window_q[1];
    window_q[1] = window_q[2];
    window_q[2] = window_q[3];
    window_q[3] = x;
    if (seen_q >= sdfa_pkg::WARMUP) begin
      dc_sum_q += diff * centre;
      cc_sum_q += centre * centre;
    end else begin
      seen_q++;
    end
    if (last) begin
      res.numerator   = -dc_sum_q;
      res.denominator = cc_sum_q;
      run_results_q.push_back(res);
      clear_run();
    end
  endtask

  // Sample both handshakes on the edge
  always @(posedge clk_i or negedge rst_ni) begin
    sdfa_pkg::result_t want;
    if (!rst_ni) begin
      clear_run();
      run_results_q.delete();
    end else begin
      if (pop && !empty) begin
        if (run_results_q.size() == 0) begin
          log_error($sformatf("result item with no run end pending: num %h den %h",
                              numerator_o, denominator_o));
        end else begin
          want = run_results_q.pop_front();
          if (numerator_o !== want.numerator)
            log_error($sformatf("numerator got %h want %h", numerator_o, want.numerator));
          if (denominator_o !== want.denominator)
            log_error($sformatf("denominator got %h want %h",
                                denominator_o, want.denominator));
        end
      end
      if (push && !full) take_sample(sample_i, end_of_run_i);
    end
    error_count_o <= errors;
    pending_o     <= run_results_q.size();
  end

endmodule

>>> sim/second_difference_frequency_accumulator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// second_difference_frequency_accumulator_unit_tb: testbench top
// Drives sample runs into the accumulator: a few hand-picked runs around
// warm-up, short runs and the sample extremes, then random runs of mixed
// length under three push/pop idling patterns. The checker beside the block
// predicts and compares; this module only makes stimulus and decides.
// ----------------------------------------------------------------------------

module second_difference_frequency_accumulator_unit_tb;

  localparam int CLK_PERIOD   = 4;
  localparam int PHASE_ITEMS  = 215;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni;
  logic                                 push;
  logic                                 full;
  logic signed [sdfa_pkg::SAMPLE_W-1:0] sample_i;
  logic                                 end_of_run_i;
  logic                                 empty;
  logic                                 pop = 1'b0;
  logic signed [sdfa_pkg::ACC_W-1:0]    numerator_o;
  logic signed [sdfa_pkg::ACC_W-1:0]    denominator_o;

  int errors;
  int pending;
  int push_idle_pct = 0;
  int pop_idle_pct  = 0;
  int items_sent    = 0;
  int cycle_count   = 0;

  second_difference_frequency_accumulator_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .sample_i      (sample_i),
    .end_of_run_i  (end_of_run_i),
    .empty         (empty),
    .pop           (pop),
    .numerator_o   (numerator_o),
    .denominator_o (denominator_o)
  );

  frequency_sum_checker sum_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .sample_i      (sample_i),
    .end_of_run_i  (end_of_run_i),
    .empty         (empty),
    .pop           (pop),
    .numerator_o   (numerator_o),
    .denominator_o (denominator_o),
    .error_count_o (errors),
    .pending_o     (pending)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Receiver: random pop stalls
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("second_difference_frequency_accumulator_unit_tb: errors");
      $finish;
    end
  end

  // Offer one item, with random idle cycles ahead of it, until it is taken
  task automatic send_item(input int s, input bit last);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    sample_i     <= s[sdfa_pkg::SAMPLE_W-1:0];
    end_of_run_i <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
  endtask

  // Hold off until every queued result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic int random_sample();
    case ($urandom_range(3))
      0: return int'($urandom_range(16)) - 8;
      1: begin
        case ($urandom_range(3))
          0: return 32767;
          1: return -32768;
          2: return -1;
          default: return 0;
        endcase
      end
      default: return int'($urandom_range(65535));
    endcase
  endfunction

  // Mostly short runs, some long ones
  task automatic random_run();
    int len;
    case ($urandom_range(9))
      0: len = $urandom_range(120, 41);
      1, 2: len = $urandom_range(40, 13);
      default: len = $urandom_range(12, 1);
    endcase
    for (int i = 0; i < len; i++) send_item(random_sample(), i == len - 1);
  endtask

  task automatic random_phase(input int send_idle, input int recv_idle);
    int stop_at;
    push_idle_pct = send_idle;
    pop_idle_pct  = recv_idle;
    stop_at       = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) random_run();
  endtask

  initial begin
    rst_ni       = 1'b0;
    push         = 1'b0;
    sample_i     = '0;
    end_of_run_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Run of one sample: reports zeros
    send_item(0, 1'b1);
    // Four samples: window fills, nothing summed
    send_item(32767, 1'b0);
    send_item(-32768, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b1);
    // Five samples: largest second difference around the most negative centre
    send_item(32767, 1'b0);
    send_item(0, 1'b0);
    send_item(-32768, 1'b0);
    send_item(0, 1'b0);
    send_item(32767, 1'b1);
    // Seven samples: three terms, mixed signs
    send_item(-32768, 1'b0);
    send_item(5, 1'b0);
    send_item(32767, 1'b0);
    send_item(-5, 1'b0);
    send_item(-32768, 1'b0);
    send_item(100, 1'b0);
    send_item(-32768, 1'b1);
    // Six samples all at -1, then all at the positive extreme
    repeat (5) send_item(-1, 1'b0);
    send_item(-1, 1'b1);
    repeat (5) send_item(32767, 1'b0);
    send_item(32767, 1'b1);
    wait_drained();

    random_phase(38, 48);
    wait_drained();
    random_phase(48, 38);
    random_phase(0, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("second_difference_frequency_accumulator_unit_tb: clean");
    end else begin
      $display("second_difference_frequency_accumulator_unit_tb: errors");
    end
    $finish;
  end

endmodule

>>> second_difference_frequency_accumulator_unit.f
hdl/sdfa_pkg.sv
hdl/sdfa_front.sv
hdl/sdfa_term_queue.sv
hdl/sdfa_back.sv
hdl/second_difference_frequency_accumulator_unit.sv
sim/frequency_sum_checker.sv
sim/second_difference_frequency_accumulator_unit_tb.sv
